>>> design/bps_pkg.sv
// ----------------------------------------------------------------------------
// Bounce particle step package
// Shared widths, constants, register codes and types for the particle block.
// ----------------------------------------------------------------------------
package bps_pkg;

    // Fixed-point format of positions and velocities.
    localparam int DW         = 32;
    localparam int FRAC_BITS  = 16;

    // Damping is unsigned Q1.16 and one is 2^16.
    localparam int DAMP_W     = 17;
    localparam int DAMP_SHIFT = 16;
    localparam logic [DAMP_W-1:0] DAMP_ONE = DAMP_W'(65536);

    // Coefficient width of the serial multiplier: wide enough for the
    // friction factor and for the damping value.
    localparam int CW       = (FRAC_BITS > DAMP_W) ? FRAC_BITS : DAMP_W;
    localparam int CNT_W    = $clog2(CW + 1);
    localparam int FRICTION_I = ((99 << FRAC_BITS) + 50) / 100;
    localparam logic [CW-1:0] FRICTION = CW'(FRICTION_I);

    // Configuration register index codes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY    = 3'd0,
        CFG_DAMPING    = 3'd1,
        CFG_WALL_LEFT  = 3'd2,
        CFG_WALL_RIGHT = 3'd3,
        CFG_FLOOR      = 3'd4
    } t_cfg_idx;

    // Request kinds carried in tuser.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic signed [DW-1:0] gravity;
        logic [DAMP_W-1:0]    damping;   // already limited to one
        logic signed [DW-1:0] wall_left;
        logic signed [DW-1:0] wall_right;
        logic signed [DW-1:0] floor_level;
    } t_cfg;

    // Control of one multiplication.
    typedef struct packed {
        logic start;
        logic fric;   // friction shift, otherwise damping shift
        logic neg;    // negate the product (reflection)
    } t_mul_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRIC,
        ST_POS,
        ST_LEFT,
        ST_LEFT_MUL,
        ST_RIGHT,
        ST_RIGHT_MUL,
        ST_FLOOR,
        ST_FLOOR_MUL,
        ST_OUT
    } t_state;

endpackage

>>> design/bps_cfg.sv
// ----------------------------------------------------------------------------
// Bounce particle configuration registers
// Decodes register writes and presents the current physics settings.
// ----------------------------------------------------------------------------
module bps_cfg import bps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [DW-1:0]        i_data,
    output t_cfg                 o_cfg
);

    logic signed [DW-1:0] r_gravity;
    logic [DAMP_W-1:0]    r_damping;
    logic signed [DW-1:0] r_wall_left;
    logic signed [DW-1:0] r_wall_right;
    logic signed [DW-1:0] r_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity    <= DW'(32768);
            r_damping    <= DAMP_W'(52429);
            r_wall_left  <= '0;
            r_wall_right <= DW'(8388608);
            r_floor      <= DW'(4194304);
        end else if (i_wr) begin
            case (t_cfg_idx'(i_index))
                CFG_GRAVITY:    r_gravity    <= i_data;
                CFG_DAMPING:    r_damping    <= i_data[DAMP_W-1:0];
                CFG_WALL_LEFT:  r_wall_left  <= i_data;
                CFG_WALL_RIGHT: r_wall_right <= i_data;
                CFG_FLOOR:      r_floor      <= i_data;
                default: ;
            endcase
        end
    end

    // Retention factors above one behave as one.
    always_comb begin
        o_cfg.gravity     = r_gravity;
        o_cfg.damping     = (r_damping > DAMP_ONE) ? DAMP_ONE : r_damping;
        o_cfg.wall_left   = r_wall_left;
        o_cfg.wall_right  = r_wall_right;
        o_cfg.floor_level = r_floor;
    end

endmodule

>>> design/bps_serial_mul.sv
// ----------------------------------------------------------------------------
// Bounce particle serial multiplier
// Shift-add multiply of a velocity magnitude by a coefficient, one coefficient
// bit per cycle, then round half away from zero and saturate.
// ----------------------------------------------------------------------------
module bps_serial_mul import bps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mul_req             i_req,
    input  logic signed [DW-1:0] i_val,
    input  logic [CW-1:0]        i_coef,
    output logic                 o_done,
    output logic signed [DW-1:0] o_result
);

    localparam int PW = DW + CW;

    logic                 r_busy;
    logic                 r_round;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DW-1:0]        r_mag;
    logic [CW-1:0]        r_coef;
    logic [DW-1:0]        r_hi;
    logic [CW-1:0]        r_lo;
    logic                 r_neg;
    logic                 r_fric;
    logic signed [DW-1:0] r_result;

    logic [DW:0]          w_sum;
    logic [PW-1:0]        w_prod;
    logic [PW:0]          w_rnd;
    logic [PW:0]          w_shr;
    logic                 w_pos_over;
    logic                 w_neg_over;
    logic signed [DW-1:0] w_result;

    always_comb begin
        w_sum  = {1'b0, r_hi} + {1'b0, (r_coef[0] ? r_mag : '0)};
        w_prod = {r_hi, r_lo};
        if (r_fric) begin
            w_rnd = {1'b0, w_prod} + ((PW+1)'(1) << (FRAC_BITS - 1));
            w_shr = w_rnd >> FRAC_BITS;
        end else begin
            w_rnd = {1'b0, w_prod} + ((PW+1)'(1) << (DAMP_SHIFT - 1));
            w_shr = w_rnd >> DAMP_SHIFT;
        end
        w_pos_over = |w_shr[PW:DW-1];
        w_neg_over = (|w_shr[PW:DW]) || (w_shr[DW-1] && (|w_shr[DW-2:0]));
        if (r_neg) begin
            w_result = w_neg_over ? {1'b1, {(DW-1){1'b0}}} : -$signed(w_shr[DW-1:0]);
        end else begin
            w_result = w_pos_over ? {1'b0, {(DW-1){1'b1}}} : $signed(w_shr[DW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(CW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy  <= 1'b0;
                    r_round <= 1'b1;
                end
            end else if (r_round) begin
                r_round <= 1'b0;
                r_done  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mag  <= i_val[DW-1] ? (~i_val + 1'b1) : i_val;
            r_coef <= i_coef;
            r_hi   <= '0;
            r_lo   <= '0;
            r_neg  <= i_val[DW-1] ^ i_req.neg;
            r_fric <= i_req.fric;
        end else if (r_busy) begin
            r_hi   <= w_sum[DW:1];
            r_lo   <= {w_sum[0], r_lo[CW-1:1]};
            r_coef <= {1'b0, r_coef[CW-1:1]};
        end
        if (r_round) begin
            r_result <= w_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> design/bounce_particle_step.sv
// ----------------------------------------------------------------------------
// Bounce particle step
// One particle under gravity with side walls and a floor, Q16.16 state.
// ----------------------------------------------------------------------------
// The block holds one particle (x, y, vx, vy in signed Q16.16) and handles one
// request at a time on the s_ stream. A request with tuser set loads all four
// values, which pass through ST_OUT into the output register once that
// register is empty or its result is being taken. A request with tuser clear
// applies one Euler step: friction on vx, gravity on vy, position update, then
// wall and floor contacts with damped reflection. Every multiply runs through
// a single bit-serial shift-add multiplier that takes one coefficient bit per
// cycle. A step without contact uses it once, for friction, and each wall or
// floor contact adds one more multiply. The result sits in an output register,
// so a new request is taken while a finished result still waits on m_tready.
// Configuration writes are always taken and must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module bounce_particle_step import bps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [4*DW-1:0]      s_tdata,   // load_pos_x, load_pos_y, load_vel_x, load_vel_y
    input  logic [0:0]           s_tuser,   // req_type
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [4*DW-1:0]      m_tdata,   // pos_x, pos_y, vel_x, vel_y
    output logic [0:0]           m_tuser,   // bounced
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DW-1:0]        i_cfg_data
);

    // Add two signed values and clamp to the 32-bit range.
    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            sat_add = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            sat_add = s[DW-1:0];
        end
    endfunction

    localparam logic signed [DW-1:0] HALF_POS = DW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DW-1:0] HALF_NEG = -HALF_POS;

    t_cfg     w_cfg;
    t_state   r_state;
    t_state   n_state;
    t_mul_req w_mul_req;
    logic     w_mul_vy;     // multiply vy rather than vx
    logic     w_out_load;
    logic     w_accept;
    logic     w_mul_done;
    logic signed [DW-1:0] w_mul_res;
    logic signed [DW-1:0] w_mul_val;
    logic [CW-1:0]        w_mul_coef;

    logic signed [DW-1:0] r_pos_x;
    logic signed [DW-1:0] r_pos_y;
    logic signed [DW-1:0] r_vel_x;
    logic signed [DW-1:0] r_vel_y;
    logic                 r_bounced;

    logic                 r_m_valid;
    logic [4*DW-1:0]      r_m_data;
    logic                 r_m_user;

    logic w_hit_left;
    logic w_hit_right;
    logic w_hit_floor;

    bps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign o_cfg_ready = 1'b1;

    assign w_hit_left  = r_pos_x < w_cfg.wall_left;
    assign w_hit_right = r_pos_x > w_cfg.wall_right;
    assign w_hit_floor = r_pos_y >= w_cfg.floor_level;
    assign w_accept    = s_tvalid && s_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = (s_tuser[0] == REQ_LOAD) ? ST_OUT : ST_FRIC;
                end
            end
            ST_FRIC:      if (w_mul_done) n_state = ST_POS;
            ST_POS:       n_state = ST_LEFT;
            ST_LEFT:      n_state = w_hit_left ? ST_LEFT_MUL : ST_RIGHT;
            ST_LEFT_MUL:  if (w_mul_done) n_state = ST_RIGHT;
            ST_RIGHT:     n_state = w_hit_right ? ST_RIGHT_MUL : ST_FLOOR;
            ST_RIGHT_MUL: if (w_mul_done) n_state = ST_FLOOR;
            ST_FLOOR:     n_state = w_hit_floor ? ST_FLOOR_MUL : ST_OUT;
            ST_FLOOR_MUL: if (w_mul_done) n_state = ST_OUT;
            ST_OUT:       if (w_out_load) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_tready   = 1'b0;
        w_mul_req  = '0;
        w_mul_vy   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser[0] == REQ_TICK) begin
                    w_mul_req.start = 1'b1;
                    w_mul_req.fric  = 1'b1;
                end
            end
            ST_LEFT: begin
                w_mul_req.start = w_hit_left;
                w_mul_req.neg   = 1'b1;
            end
            ST_RIGHT: begin
                w_mul_req.start = w_hit_right;
                w_mul_req.neg   = 1'b1;
            end
            ST_FLOOR: begin
                w_mul_req.start = w_hit_floor;
                w_mul_req.neg   = 1'b1;
                w_mul_vy        = 1'b1;
            end
            ST_OUT: begin
                w_out_load = !r_m_valid || m_tready;
            end
            default: ;
        endcase
    end

    // The friction request starts in the accept cycle, before x moves, and
    // each wall test sees the x written by the previous test.
    assign w_mul_val  = w_mul_vy ? r_vel_y : r_vel_x;
    assign w_mul_coef = w_mul_req.fric ? FRICTION : CW'(w_cfg.damping);

    bps_serial_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mul_req),
        .i_val    (w_mul_val),
        .i_coef   (w_mul_coef),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Particle state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_vel_x   <= '0;
            r_vel_y   <= '0;
            r_bounced <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_bounced <= 1'b0;
                        if (s_tuser[0] == REQ_LOAD) begin
                            r_pos_x <= s_tdata[DW-1:0];
                            r_pos_y <= s_tdata[2*DW-1:DW];
                            r_vel_x <= s_tdata[3*DW-1:2*DW];
                            r_vel_y <= s_tdata[4*DW-1:3*DW];
                        end
                    end
                end
                ST_FRIC: begin
                    if (w_mul_done) begin
                        r_vel_x <= w_mul_res;
                        r_vel_y <= sat_add(r_vel_y, w_cfg.gravity);
                    end
                end
                ST_POS: begin
                    r_pos_x <= sat_add(r_pos_x, r_vel_x);
                    r_pos_y <= sat_add(r_pos_y, r_vel_y);
                end
                ST_LEFT: begin
                    if (w_hit_left) begin
                        r_pos_x   <= w_cfg.wall_left;
                        r_bounced <= 1'b1;
                    end
                end
                ST_RIGHT: begin
                    if (w_hit_right) begin
                        r_pos_x   <= w_cfg.wall_right;
                        r_bounced <= 1'b1;
                    end
                end
                ST_FLOOR: begin
                    if (w_hit_floor) begin
                        r_pos_y   <= w_cfg.floor_level;
                        r_bounced <= 1'b1;
                    end
                end
                ST_LEFT_MUL, ST_RIGHT_MUL: begin
                    if (w_mul_done) begin
                        r_vel_x <= w_mul_res;
                    end
                end
                ST_FLOOR_MUL: begin
                    if (w_mul_done) begin
                        // A rebound slower than half a unit comes to rest.
                        if (w_mul_res > HALF_NEG && w_mul_res < HALF_POS) begin
                            r_vel_y <= '0;
                        end else begin
                            r_vel_y <= w_mul_res;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {r_vel_y, r_vel_x, r_pos_y, r_pos_x};
            r_m_user <= r_bounced;
        end
    end

    assign m_tvalid   = r_m_valid;
    assign m_tdata    = r_m_data;
    assign m_tuser[0] = r_m_user;

endmodule

>>> design/bps_checker.sv
// ----------------------------------------------------------------------------
// Bounce particle port checker
// Watches the ports of the particle block and flags sequencing errors.
// ----------------------------------------------------------------------------
module bps_checker import bps_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic [4*DW-1:0] s_tdata,
    input logic [0:0]      s_tuser,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [4*DW-1:0] m_tdata,
    input logic [0:0]      m_tuser
);

    // A held result does not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only one request is in work at a time.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // A load taken while the output is empty echoes its values with no contact.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> ##1
            m_tvalid && m_tdata == $past(s_tdata, 2) && !m_tuser[0])
        else $error("load result wrong");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind bounce_particle_step bps_checker u_bps_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounce particle step testbench
// Drives load and tick requests into the particle block and checks every result.
// ----------------------------------------------------------------------------
// A short table of directed rows runs first. It covers register writes, loads
// of the field extremes, wall and floor contacts, crossed walls, damping above
// one and the reflection of the most negative velocity. Six random phases
// follow. Each phase first writes all five registers, either with plausible
// physics settings or with raw random words. Most random requests are ticks;
// one in ten is a load, and most loads restart the particle near the walls
// and the floor. A model of the particle, kept in this file, predicts
// each result when its request is accepted. The result stream is compared
// field by field, in order, against those predictions. Both stream sides idle
// at random, except in one phase that runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import bps_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 192;
    localparam int IDLE_PERCENT    = 33;
    localparam int REPORT_LIMIT    = 10;
    // The slowest request, with its output stalls added, stays well below this limit.
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 100;

    typedef logic signed [DW-1:0] t_q16;

    localparam t_q16 Q_MAX = 32'h7FFF_FFFF;
    localparam t_q16 Q_MIN = 32'h8000_0000;
    localparam int   UNIT  = 1 << FRAC_BITS;
    localparam logic [63:0] FRIC_FACTOR = ((64'd99 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint HALF_UNIT = longint'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        t_q16 px;
        t_q16 py;
        t_q16 vx;
        t_q16 vy;
        logic bounced;
    } t_motion;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_STEP,
        ROW_STEP_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    reg_idx;
        logic [DW-1:0] value;
        logic        load;
        t_q16        x;
        t_q16        y;
        t_q16        vx;
        t_q16        vy;
        t_motion     want;
    } t_plan_row;

    // ------------------------------------------------------------------------
    // Block connections
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [4*DW-1:0]      s_tdata     = '0;   // load_pos_x, load_pos_y, load_vel_x, load_vel_y
    logic [0:0]           s_tuser     = '0;   // req_type
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [4*DW-1:0]      m_tdata;            // pos_x, pos_y, vel_x, vel_y
    logic [0:0]           m_tuser;            // bounced
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DW-1:0]        i_cfg_data  = '0;

    bounce_particle_step DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Particle model: its own copy of the state and the registers
    // ------------------------------------------------------------------------
    t_q16 part_x, part_y, part_vx, part_vy;
    t_q16 grav_set, left_set, right_set, floor_set;
    logic [DAMP_W-1:0] damp_set;

    t_motion   awaited_states[$];
    t_plan_row plan[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        stall_cycles = 0;
    bit        no_idle      = 1'b0;

    function automatic int idle_pct();
        return no_idle ? 0 : IDLE_PERCENT;
    endfunction

    function automatic t_q16 clip32(longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return t_q16'(v);
    endfunction

    // Product of a magnitude and a coefficient, rounded half away from zero
    // and saturated. The reflect flag negates the result.
    function automatic t_q16 scale_round(t_q16 v, logic [63:0] coef, int shift, bit reflect);
        bit          flip_sign;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] rounded;
        flip_sign = (v < 0) != reflect;
        mag       = (v < 0) ? 64'(-longint'(v)) : 64'(longint'(v));
        prod      = mag * coef;
        rounded   = (prod + (64'd1 << (shift - 1))) >> shift;
        if (flip_sign) begin
            return (rounded > 64'h8000_0000) ? Q_MIN : clip32(-longint'(rounded));
        end
        return (rounded > 64'h7FFF_FFFF) ? Q_MAX : t_q16'(rounded);
    endfunction

    // Applies one request to the model and returns the state that the block
    // should report for it.
    function automatic t_motion advance_particle(bit load, t_q16 lx, t_q16 ly,
                                                 t_q16 lvx, t_q16 lvy);
        t_motion           res;
        logic [DAMP_W-1:0] damp_eff;
        longint            vy_mag;
        res.bounced = 1'b0;
        if (load) begin
            part_x  = lx;
            part_y  = ly;
            part_vx = lvx;
            part_vy = lvy;
        end else begin
            damp_eff = (damp_set > DAMP_ONE) ? DAMP_ONE : damp_set;
            part_vx  = scale_round(part_vx, FRIC_FACTOR, FRAC_BITS, 1'b0);
            part_vy  = clip32(longint'(part_vy) + longint'(grav_set));
            part_x   = clip32(longint'(part_x) + longint'(part_vx));
            part_y   = clip32(longint'(part_y) + longint'(part_vy));
            // The right wall is tested on the outcome of the left test, so
            // crossed walls can clamp and reflect twice.
            if (part_x < left_set) begin
                part_x      = left_set;
                part_vx     = scale_round(part_vx, damp_eff, DAMP_SHIFT, 1'b1);
                res.bounced = 1'b1;
            end
            if (part_x > right_set) begin
                part_x      = right_set;
                part_vx     = scale_round(part_vx, damp_eff, DAMP_SHIFT, 1'b1);
                res.bounced = 1'b1;
            end
            if (part_y >= floor_set) begin
                part_y      = floor_set;
                part_vy     = scale_round(part_vy, damp_eff, DAMP_SHIFT, 1'b1);
                vy_mag      = (part_vy < 0) ? -longint'(part_vy) : longint'(part_vy);
                if (vy_mag < HALF_UNIT) part_vy = '0;
                res.bounced = 1'b1;
            end
        end
        res.px = part_x;
        res.py = part_y;
        res.vx = part_vx;
        res.vy = part_vy;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void add_write(t_cfg_idx idx, logic [DW-1:0] value);
        t_plan_row row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = value;
        plan.push_back(row);
    endfunction

    function automatic void add_step(bit load, t_q16 x, t_q16 y, t_q16 vx, t_q16 vy);
        t_plan_row row;
        row      = '0;
        row.kind = ROW_STEP;
        row.load = load;
        row.x    = x;
        row.y    = y;
        row.vx   = vx;
        row.vy   = vy;
        plan.push_back(row);
    endfunction

    // A row whose result is plain to see, so it is written out by hand.
    function automatic void add_known(bit load, t_q16 x, t_q16 y, t_q16 vx, t_q16 vy,
                                      t_q16 px, t_q16 py, t_q16 pvx, t_q16 pvy,
                                      logic hit);
        t_plan_row row;
        row              = '0;
        row.kind         = ROW_STEP_KNOWN;
        row.load         = load;
        row.x            = x;
        row.y            = y;
        row.vx           = vx;
        row.vy           = vy;
        row.want.px      = px;
        row.want.py      = py;
        row.want.vx      = pvx;
        row.want.vy      = pvy;
        row.want.bounced = hit;
        plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Ready is sampled at the falling edge. Inputs only move at rising edges,
    // so that value holds at the next rising edge, where the request is taken.
    task automatic send_request(bit load, t_q16 x, t_q16 y, t_q16 vx, t_q16 vy,
                                bit known, t_motion want);
        bit      fire;
        t_motion pred;
        while ($urandom_range(0, 99) < idle_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= load ? REQ_LOAD : REQ_TICK;
        s_tdata  <= {vy, vx, y, x};
        do begin
            @(negedge i_clk);
            fire = s_tvalid && s_tready;
            @(posedge i_clk);
        end while (!fire);
        pred = advance_particle(load, x, y, vx, vy);
        awaited_states.push_back(known ? want : pred);
    endtask

    // Stops the request stream and waits until every result has been taken.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_states.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DW-1:0] value);
        bit fire;
        quiesce();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            fire = i_cfg_valid && o_cfg_ready;
            @(posedge i_clk);
        end while (!fire);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GRAVITY:    grav_set  = value;
            CFG_DAMPING:    damp_set  = value[DAMP_W-1:0];
            CFG_WALL_LEFT:  left_set  = value;
            CFG_WALL_RIGHT: right_set = value;
            CFG_FLOOR:      floor_set = value;
            default: ;
        endcase
    endtask

    // Writes all five registers for one random phase. Plausible settings keep
    // the particle bouncing between nearby walls. Wild ones use raw words.
    task automatic choose_settings(bit wild);
        t_q16          g, lft, rgt, flr, tmp;
        logic [DW-1:0] dmp;
        if (wild) begin
            g   = $urandom;
            dmp = $urandom;
            lft = $urandom;
            rgt = $urandom;
            flr = $urandom;
        end else begin
            g   = int'($urandom_range(0, 3 * UNIT)) - UNIT / 2;
            dmp = ($urandom << DAMP_W) | $urandom_range(0, 70000);
            lft = -int'($urandom_range(0, 100 * UNIT));
            rgt = lft + int'($urandom_range(UNIT, 300 * UNIT));
            flr = int'($urandom_range(0, 200 * UNIT)) - 20 * UNIT;
            if ($urandom_range(0, 4) == 0) begin
                tmp = lft;
                lft = rgt;
                rgt = tmp;
            end
        end
        write_reg(CFG_GRAVITY, g);
        write_reg(CFG_DAMPING, dmp);
        write_reg(CFG_WALL_LEFT, lft);
        write_reg(CFG_WALL_RIGHT, rgt);
        write_reg(CFG_FLOOR, flr);
    endtask

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct());
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic note_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
            end
        end
    endtask

    always @(negedge i_clk) begin
        t_motion want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (awaited_states.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result %0d arrived with no request outstanding", results_seen);
                end
            end else begin
                want = awaited_states.pop_front();
                note_field("pos_x", want.px, m_tdata[DW-1:0]);
                note_field("pos_y", want.py, m_tdata[2*DW-1:DW]);
                note_field("vel_x", want.vx, m_tdata[3*DW-1:2*DW]);
                note_field("vel_y", want.vy, m_tdata[4*DW-1:3*DW]);
                note_field("bounced", DW'(want.bounced), DW'(m_tuser[0]));
            end
            results_seen++;
        end
    end

    // The watchdog counts only cycles in which something is pending and
    // nothing moves on any channel.
    always @(negedge i_clk) begin
        if (!(s_tvalid || i_cfg_valid || awaited_states.size() != 0) ||
            (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_motion no_result;
        int      pick;
        t_q16    ld_x, ld_y, ld_vx, ld_vy;

        no_result = '0;
        part_x    = '0;
        part_y    = '0;
        part_vx   = '0;
        part_vy   = '0;
        grav_set  = 32768;
        damp_set  = 52429;
        left_set  = 0;
        right_set = 8388608;
        floor_set = 4194304;

        // A tick from the reset state just adds gravity.
        add_known(1'b0, 0, 0, 0, 0, 0, 32768, 0, 32768, 1'b0);
        // A load returns the loaded values.
        add_known(1'b1, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 1'b0);
        add_step(1'b0, 0, 0, 0, 0);
        add_step(1'b0, 0, 0, 0, 0);
        // Just above the floor, falling onto it.
        add_known(1'b1, 10 * UNIT, 63 * UNIT, -2 * UNIT, 3 * UNIT,
                  10 * UNIT, 63 * UNIT, -2 * UNIT, 3 * UNIT, 1'b0);
        add_step(1'b0, 0, 0, 0, 0);
        add_step(1'b0, 0, 0, 0, 0);
        // Into the left wall, then into the right wall.
        add_known(1'b1, UNIT, 0, -5 * UNIT, 0, UNIT, 0, -5 * UNIT, 0, 1'b0);
        add_step(1'b0, 0, 0, 0, 0);
        add_known(1'b1, 127 * UNIT, 0, 5 * UNIT, 0, 127 * UNIT, 0, 5 * UNIT, 0, 1'b0);
        add_step(1'b0, 0, 0, 0, 0);
        // A slow floor contact: the damped speed falls below one half and is cleared.
        add_known(1'b1, 0, 64 * UNIT - 1, 0, 0, 0, 64 * UNIT - 1, 0, 0, 1'b0);
        add_step(1'b0, 0, 0, 0, 0);
        // Damping above one acts as one. The most negative velocity then
        // reflects to the largest positive value.
        add_write(CFG_GRAVITY, 0);
        add_write(CFG_DAMPING, 32'hFFFF_FFFF);
        add_write(CFG_FLOOR, Q_MIN);
        add_known(1'b1, 0, 0, 0, Q_MIN, 0, 0, 0, Q_MIN, 1'b0);
        add_known(1'b0, 0, 0, 0, 0, 0, Q_MIN, 0, Q_MAX, 1'b1);
        // Crossed walls with zero damping, plus the largest gravity.
        add_write(CFG_WALL_LEFT, 100 * UNIT);
        add_write(CFG_WALL_RIGHT, -100 * UNIT);
        add_write(CFG_DAMPING, 0);
        add_write(CFG_GRAVITY, Q_MAX);
        add_write(CFG_FLOOR, Q_MAX);
        add_step(1'b1, 0, 0, 3 * UNIT, Q_MAX);
        add_step(1'b0, 0, 0, 0, 0);
        // Widest walls, the most negative gravity, unit damping.
        add_write(CFG_GRAVITY, Q_MIN);
        add_write(CFG_WALL_LEFT, Q_MIN);
        add_write(CFG_WALL_RIGHT, Q_MAX);
        add_write(CFG_FLOOR, 0);
        add_write(CFG_DAMPING, 65536);
        add_step(1'b1, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
        add_step(1'b0, 0, 0, 0, 0);
        add_step(1'b0, 0, 0, 0, 0);
        add_known(1'b1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b0);
        add_step(1'b0, 0, 0, 0, 0);
        // Back to the reset settings.
        add_write(CFG_GRAVITY, 32768);
        add_write(CFG_DAMPING, 52429);
        add_write(CFG_WALL_LEFT, 0);
        add_write(CFG_WALL_RIGHT, 8388608);
        add_write(CFG_FLOOR, 4194304);
        add_step(1'b0, 0, 0, 0, 0);
        add_step(1'b0, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE:
                    write_reg(plan[i].reg_idx, plan[i].value);
                ROW_STEP:
                    send_request(plan[i].load, plan[i].x, plan[i].y, plan[i].vx,
                                 plan[i].vy, 1'b0, no_result);
                default:
                    send_request(plan[i].load, plan[i].x, plan[i].y, plan[i].vx,
                                 plan[i].vy, 1'b1, plan[i].want);
            endcase
        end

        // Random phases. Phase two uses raw register words. Phase three runs
        // with no idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            no_idle = 1'b0;
            choose_settings(phase == 2);
            no_idle = (phase == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick  = $urandom_range(0, 99);
                ld_x  = $urandom;
                ld_y  = $urandom;
                ld_vx = $urandom;
                ld_vy = $urandom;
                // Most loads put the particle near the walls and at or above
                // the floor, so that the ticks after them hit both.
                if (pick < 7) begin
                    ld_x  = int'($urandom_range(0, 400 * UNIT)) - 100 * UNIT;
                    ld_y  = floor_set - int'($urandom_range(0, 120 * UNIT));
                    ld_vx = int'($urandom_range(0, 32 * UNIT)) - 16 * UNIT;
                    ld_vy = int'($urandom_range(0, 32 * UNIT)) - 16 * UNIT;
                end
                send_request(pick < 10, ld_x, ld_y, ld_vx, ld_vy, 1'b0, no_result);
            end
        end

        no_idle = 1'b0;
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
